// ===== rtl/hvd_pkg.sv =====
// ---------------------------------------------------------------------------
// hvd_pkg
// Shared widths, fixed-point constants and the CORDIC arctangent table for
// the haversine distance pipeline.
// ---------------------------------------------------------------------------
package hvd_pkg;

	localparam int CORDIC_STAGES = 24;
	localparam int SQRT_STAGES   = 31;   // one result bit per stage, 31-bit root

	localparam int CW    = 34;           // CORDIC datapath width, signed Q30
	localparam int ANG_W = 35;           // unreduced angle width, signed Q30

	localparam logic signed [CW-1:0]    Q30_HALF_PI = 34'sd1686629713;
	localparam logic signed [ANG_W-1:0] Q30_PI      = 35'sd3373259426;
	localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 35'sd6746518852;
	localparam logic signed [CW-1:0]    CORDIC_GAIN = 34'sd652032874;
	localparam logic [30:0]             Q30_ONE     = 31'd1073741824;
	localparam logic signed [27:0]      DEG_TO_RAD  = 28'sd74961321;
	localparam logic [28:0]             RANGE_MAX   = 29'h1FFFFFFF;
	localparam logic [22:0]             RADIUS_RST  = 23'd6371000;

	typedef logic signed [CW-1:0] cdata_t;

	// atan(2^-i) in Q30
	function automatic cdata_t atan_q30(input int idx);
		cdata_t v;
		case (idx)
			0:  v = 34'sd843314857;
			1:  v = 34'sd497837829;
			2:  v = 34'sd263043837;
			3:  v = 34'sd133525159;
			4:  v = 34'sd67021687;
			5:  v = 34'sd33543516;
			6:  v = 34'sd16775851;
			7:  v = 34'sd8388437;
			8:  v = 34'sd4194283;
			9:  v = 34'sd2097149;
			10: v = 34'sd1048576;
			11: v = 34'sd524288;
			12: v = 34'sd262144;
			13: v = 34'sd131072;
			14: v = 34'sd65536;
			15: v = 34'sd32768;
			16: v = 34'sd16384;
			17: v = 34'sd8192;
			18: v = 34'sd4096;
			19: v = 34'sd2048;
			20: v = 34'sd1024;
			21: v = 34'sd512;
			22: v = 34'sd256;
			23: v = 34'sd128;
			24: v = 34'sd64;
			25: v = 34'sd32;
			26: v = 34'sd16;
			27: v = 34'sd8;
			28: v = 34'sd4;
			29: v = 34'sd2;
			30: v = 34'sd1;
			default: v = 34'sd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/hvd_sincos.sv =====
// ---------------------------------------------------------------------------
// hvd_sincos
// Angle range reduction followed by a fully pipelined rotation CORDIC.
// ---------------------------------------------------------------------------
module hvd_sincos (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               vld_in,
	input  logic signed [hvd_pkg::ANG_W-1:0]  ang,
	output logic                               vld_out,
	output logic signed [31:0]                 sin_out,
	output logic signed [31:0]                 cos_out
);
	import hvd_pkg::*;

	localparam int N = CORDIC_STAGES;

	logic                    vld_s1, vld_s2;
	logic signed [ANG_W-1:0] r_s1;
	cdata_t                  z_s2;
	logic                    neg_s2;
	logic signed [ANG_W-1:0] wrap_c;
	logic signed [ANG_W-1:0] fold_c;
	logic                    neg_c;

	cdata_t cx_s [1:N];
	cdata_t cy_s [1:N];
	cdata_t cz_s [1:N];
	logic   cn_s [1:N];
	logic   cv_s [1:N];

	// wrap into [-pi, pi]
	always_comb begin
		if (ang > Q30_PI)
			wrap_c = ang - Q30_TWO_PI;
		else if (ang < -Q30_PI)
			wrap_c = ang + Q30_TWO_PI;
		else
			wrap_c = ang;
	end

	// fold into [-pi/2, pi/2], flip both outputs
	always_comb begin
		neg_c = 1'b0;
		fold_c = r_s1;
		if (r_s1 > ANG_W'(Q30_HALF_PI)) begin
			fold_c = r_s1 - Q30_PI;
			neg_c = 1'b1;
		end else if (r_s1 < -ANG_W'(Q30_HALF_PI)) begin
			fold_c = r_s1 + Q30_PI;
			neg_c = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1   <= wrap_c;
			z_s2   <= CW'(fold_c);
			neg_s2 <= neg_c;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		cdata_t xi, yi, zi, dx, dy;
		logic   ni, vi;

		if (i == 0) begin : g_first
			assign xi = CORDIC_GAIN;
			assign yi = '0;
			assign zi = z_s2;
			assign ni = neg_s2;
			assign vi = vld_s2;
		end else begin : g_next
			assign xi = cx_s[i];
			assign yi = cy_s[i];
			assign zi = cz_s[i];
			assign ni = cn_s[i];
			assign vi = cv_s[i];
		end

		assign dx = yi >>> i;
		assign dy = xi >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				cv_s[i+1] <= 1'b0;
			else if (en)
				cv_s[i+1] <= vi;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cn_s[i+1] <= ni;
				if (zi >= 0) begin
					cx_s[i+1] <= xi - dx;
					cy_s[i+1] <= yi + dy;
					cz_s[i+1] <= zi - atan_q30(i);
				end else begin
					cx_s[i+1] <= xi + dx;
					cy_s[i+1] <= yi - dy;
					cz_s[i+1] <= zi + atan_q30(i);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_out <= 1'b0;
		else if (en)
			vld_out <= cv_s[N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_out <= cn_s[N] ? 32'(-cy_s[N]) : 32'(cy_s[N]);
			cos_out <= cn_s[N] ? 32'(-cx_s[N]) : 32'(cx_s[N]);
		end
	end

endmodule

// ===== rtl/hvd_isqrt.sv =====
// ---------------------------------------------------------------------------
// hvd_isqrt
// Pipelined floor square root of value * 2^30, one result bit per stage.
// ---------------------------------------------------------------------------
module hvd_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vld_in,
	input  logic [30:0] value,
	output logic        vld_out,
	output logic [30:0] root
);
	import hvd_pkg::*;

	localparam int N = SQRT_STAGES;
	localparam int RW = 2 * N;

	logic [RW-1:0] rem_s [1:N];
	logic [RW-1:0] res_s [1:N];
	logic          sv_s  [1:N];

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [RW-1:0] BIT = RW'(1) << (RW - 2 - 2 * k);
		logic [RW-1:0] remi, resi, trial;
		logic          vi;

		if (k == 0) begin : g_first
			assign remi = {1'b0, value, 30'd0};
			assign resi = '0;
			assign vi   = vld_in;
		end else begin : g_next
			assign remi = rem_s[k];
			assign resi = res_s[k];
			assign vi   = sv_s[k];
		end

		assign trial = resi + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sv_s[k+1] <= 1'b0;
			else if (en)
				sv_s[k+1] <= vi;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (remi >= trial) begin
					rem_s[k+1] <= remi - trial;
					res_s[k+1] <= (resi >> 1) + BIT;
				end else begin
					rem_s[k+1] <= remi;
					res_s[k+1] <= resi >> 1;
				end
			end
		end
	end

	assign vld_out = sv_s[N];
	assign root    = res_s[N][30:0];

endmodule

// ===== rtl/hvd_atan2.sv =====
// ---------------------------------------------------------------------------
// hvd_atan2
// Pipelined vectoring CORDIC: angle of (x, y) in Q30, clamped to [0, pi/2].
// ---------------------------------------------------------------------------
module hvd_atan2 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        vld_in,
	input  logic [30:0] xin,
	input  logic [30:0] yin,
	output logic        vld_out,
	output logic [30:0] angle
);
	import hvd_pkg::*;

	localparam int N = CORDIC_STAGES;

	cdata_t vx_s [1:N];
	cdata_t vy_s [1:N];
	cdata_t vz_s [1:N];
	logic   vv_s [1:N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		cdata_t xi, yi, zi, dx, dy;
		logic   vi;

		if (i == 0) begin : g_first
			assign xi = CW'({1'b0, xin});
			assign yi = CW'({1'b0, yin});
			assign zi = '0;
			assign vi = vld_in;
		end else begin : g_next
			assign xi = vx_s[i];
			assign yi = vy_s[i];
			assign zi = vz_s[i];
			assign vi = vv_s[i];
		end

		assign dx = yi >>> i;
		assign dy = xi >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vv_s[i+1] <= 1'b0;
			else if (en)
				vv_s[i+1] <= vi;
		end

		// drive y toward zero
		always_ff @(posedge clk) begin
			if (en) begin
				if (yi >= 0) begin
					vx_s[i+1] <= xi + dx;
					vy_s[i+1] <= yi - dy;
					vz_s[i+1] <= zi + atan_q30(i);
				end else begin
					vx_s[i+1] <= xi - dx;
					vy_s[i+1] <= yi + dy;
					vz_s[i+1] <= zi - atan_q30(i);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_out <= 1'b0;
		else if (en)
			vld_out <= vv_s[N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (vz_s[N] < 0)
				angle <= '0;
			else if (vz_s[N] > Q30_HALF_PI)
				angle <= 31'(Q30_HALF_PI);
			else
				angle <= 31'(vz_s[N]);
		end
	end

endmodule

// ===== rtl/haversine_distance.sv =====
// ---------------------------------------------------------------------------
// haversine_distance
// Great-circle distance between a position in radians (Q3.28) and a target
// in degrees (Q8.23), scaled by a programmable sphere radius.
//
// Input channel: in_valid / in_stall carry one position pair per transaction.
// Output channel: out_valid / out_stall carry the distance in 1/16 m,
// saturated to 29 bits.
// cfg_we / cfg_wdata write the sphere radius in metres (reset 6371000);
// write it only while no transaction is in flight.
// The path to out_valid runs through the two CORDIC chains and the 31-stage root.
// Throughput: one transaction per cycle while in_stall is low; every stage is registered.
// When out_stall holds a result, a two-entry output buffer (output register
// plus skid register) keeps taking one more result; in_stall rises once the
// skid register fills and the whole pipeline freezes until it drains.
// Reset clears all valid bits and the buffer, and loads the default radius.
// ---------------------------------------------------------------------------
module haversine_distance (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [29:0] here_lat_rad,
	input  logic signed [30:0] here_lon_rad,
	input  logic signed [30:0] goal_lat_deg,
	input  logic signed [31:0] goal_lon_deg,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [28:0]        range_sixteenth_m,
	input  logic               cfg_we,
	input  logic [22:0]        cfg_wdata
);
	import hvd_pkg::*;

	logic        en;
	logic [22:0] radius_q;

	// front end
	logic                    vld_s1, vld_s2, vld_s3;
	logic signed [29:0]      lat_a_s1, lat_a_s2;
	logic signed [30:0]      lon_a_s1, lon_a_s2;
	logic signed [58:0]      latp_s1;
	logic signed [59:0]      lonp_s1;
	logic signed [58:0]      latr_c;
	logic signed [59:0]      lonr_c;
	logic signed [31:0]      lat_b_s2, lon_b_s2;
	logic signed [ANG_W-1:0] dlat_s3, dlon_s3, alat_s3, blat_s3;

	// trig outputs
	logic               trig_vld;
	logic signed [31:0] s_dlat, s_dlon, cos_a, cos_b;

	// haversine term
	logic               vld_p1, vld_p2, vld_p3, vld_p4;
	logic signed [63:0] sql_p1, sqo_p1, cc_p1;
	logic signed [63:0] sqlr_c, sqor_c, ccr_c;
	logic signed [31:0] sql_p2, sqo_p2, cc_p2;
	logic signed [63:0] t_p3;
	logic signed [31:0] sql_p3;
	logic signed [63:0] tr_c;
	logic signed [33:0] a_c;
	logic [30:0]        a_p4;

	// roots and angle
	logic        ys_vld;
	logic [30:0] ys, xs;
	logic        z_vld;
	logic [30:0] z;

	// scaling
	logic        vld_m1;
	logic [53:0] prod_m1;
	logic [54:0] dsum_c;
	logic [29:0] d_c;
	logic [28:0] dsat_c;

	// output buffer
	logic        skid_full_q;
	logic [28:0] skid_q;
	logic [28:0] out_q;
	logic        out_vld_q;
	logic        take;
	logic        push;

	assign en       = !skid_full_q;
	assign in_stall = skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radius_q <= RADIUS_RST;
		else if (cfg_we)
			radius_q <= cfg_wdata;
	end

	// ---- degrees to radians, angle setup ----
	assign latr_c = latp_s1 + 59'sd67108864;
	assign lonr_c = lonp_s1 + 60'sd67108864;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lat_a_s1 <= here_lat_rad;
			lon_a_s1 <= here_lon_rad;
			latp_s1  <= 59'(goal_lat_deg) * 59'(DEG_TO_RAD);
			lonp_s1  <= 60'(goal_lon_deg) * 60'(DEG_TO_RAD);

			lat_a_s2 <= lat_a_s1;
			lon_a_s2 <= lon_a_s1;
			lat_b_s2 <= latr_c[58:27];
			lon_b_s2 <= lonr_c[58:27];

			// half differences and the latitudes themselves, all as Q30
			dlat_s3 <= (ANG_W'(lat_b_s2) - ANG_W'(lat_a_s2)) <<< 1;
			dlon_s3 <= (ANG_W'(lon_b_s2) - ANG_W'(lon_a_s2)) <<< 1;
			alat_s3 <= ANG_W'(lat_a_s2) <<< 2;
			blat_s3 <= ANG_W'(lat_b_s2) <<< 2;
		end
	end

	hvd_sincos u_sc_dlat (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s3), .ang(dlat_s3),
		.vld_out(trig_vld), .sin_out(s_dlat), .cos_out()
	);

	hvd_sincos u_sc_dlon (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s3), .ang(dlon_s3),
		.vld_out(), .sin_out(s_dlon), .cos_out()
	);

	hvd_sincos u_sc_alat (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s3), .ang(alat_s3),
		.vld_out(), .sin_out(), .cos_out(cos_a)
	);

	hvd_sincos u_sc_blat (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s3), .ang(blat_s3),
		.vld_out(), .sin_out(), .cos_out(cos_b)
	);

	// ---- haversine term a ----
	assign sqlr_c = sql_p1 + 64'sd536870912;
	assign sqor_c = sqo_p1 + 64'sd536870912;
	assign ccr_c  = cc_p1  + 64'sd536870912;
	assign tr_c   = t_p3   + 64'sd536870912;
	assign a_c    = 34'(sql_p3) + 34'(tr_c[63:30]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p1 <= 1'b0;
			vld_p2 <= 1'b0;
			vld_p3 <= 1'b0;
			vld_p4 <= 1'b0;
		end else if (en) begin
			vld_p1 <= trig_vld;
			vld_p2 <= vld_p1;
			vld_p3 <= vld_p2;
			vld_p4 <= vld_p3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sql_p1 <= 64'(s_dlat) * 64'(s_dlat);
			sqo_p1 <= 64'(s_dlon) * 64'(s_dlon);
			cc_p1  <= 64'(cos_a) * 64'(cos_b);

			sql_p2 <= sqlr_c[61:30];
			sqo_p2 <= sqor_c[61:30];
			cc_p2  <= ccr_c[61:30];

			t_p3   <= 64'(cc_p2) * 64'(sqo_p2);
			sql_p3 <= sql_p2;

			// clamp to [0, 1]
			if (a_c < 0)
				a_p4 <= '0;
			else if (a_c > 34'(Q30_ONE))
				a_p4 <= Q30_ONE;
			else
				a_p4 <= 31'(a_c);
		end
	end

	// ---- central angle ----
	hvd_isqrt u_sqrt_a (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_p4), .value(a_p4),
		.vld_out(ys_vld), .root(ys)
	);

	hvd_isqrt u_sqrt_b (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_p4), .value(Q30_ONE - a_p4),
		.vld_out(), .root(xs)
	);

	hvd_atan2 u_atan (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(ys_vld), .xin(xs), .yin(ys),
		.vld_out(z_vld), .angle(z)
	);

	// ---- scale by radius ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_m1 <= 1'b0;
		else if (en)
			vld_m1 <= z_vld;
	end

	always_ff @(posedge clk) begin
		if (en)
			prod_m1 <= 54'(radius_q) * 54'(z);
	end

	assign dsum_c = 55'(prod_m1) + 55'd16777216;
	assign d_c    = dsum_c[54:25];
	assign dsat_c = (d_c > 30'(RANGE_MAX)) ? RANGE_MAX : d_c[28:0];

	// ---- output register and skid ----
	assign take = out_vld_q && !out_stall;
	assign push = en && vld_m1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (take)
				skid_full_q <= 1'b0;
		end else if (push) begin
			if (out_vld_q && !take)
				skid_full_q <= 1'b1;
			else
				out_vld_q <= 1'b1;
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (take)
				out_q <= skid_q;
		end else if (push) begin
			if (out_vld_q && !take)
				skid_q <= dsat_c;
			else
				out_q <= dsat_c;
		end
	end

	assign out_valid         = out_vld_q;
	assign range_sixteenth_m = out_q;

endmodule
